// ===== rtl/core/hlcm_pkg.sv =====
package hlcm_pkg;

	// Width of the period that takes part in the arithmetic.
	localparam int PERIOD_BITS = 16;
	// Width of the running least common multiple before saturation.
	localparam int RESULT_BITS = 48;

	// Fixed widths of the transaction fields.
	localparam int PERIOD_W = 16;
	localparam int HYPER_W  = 48;

	localparam logic [RESULT_BITS-1:0] RESULT_MAX = {RESULT_BITS{1'b1}};

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic                last;
	} hlcm_in_t;

	typedef struct packed {
		logic [HYPER_W-1:0] hyperperiod;
		logic               overflow;
		logic               final_res;
	} hlcm_out_t;

endpackage

// ===== rtl/core/hlcm_div.sv =====
module hlcm_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [hlcm_pkg::RESULT_BITS-1:0] dividend,
	input  logic [hlcm_pkg::PERIOD_BITS-1:0] divisor,
	output logic                            done,
	output logic [hlcm_pkg::RESULT_BITS-1:0] quotient,
	output logic [hlcm_pkg::PERIOD_BITS-1:0] remainder
);
	import hlcm_pkg::*;

	localparam int CNT_W = $clog2(RESULT_BITS + 1);

	logic [RESULT_BITS-1:0] quo_q;
	logic [PERIOD_BITS-1:0] rem_q;
	logic [PERIOD_BITS-1:0] dvs_q;
	logic [CNT_W-1:0]       cnt_q;
	logic                   busy_q;
	logic                   done_q;
	logic [PERIOD_BITS:0]   trial;
	logic [PERIOD_BITS:0]   diff;
	logic                   fits;

	// Restoring division, one quotient bit per cycle, quotient shifted into
	// the dividend register as the dividend bits move out.
	assign trial = {rem_q, quo_q[RESULT_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(RESULT_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[RESULT_BITS-2:0], fits};
			rem_q <= fits ? diff[PERIOD_BITS-1:0] : trial[PERIOD_BITS-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// ===== rtl/core/hyperperiod_lcm_accumulator_unit.sv =====
// Running hyperperiod (least common multiple) of a stream of task periods.
// The item channel carries one period and a last flag per transaction; the
// result channel returns one transaction per item with the running value,
// a sticky saturation flag and an echo of last. Both use valid/ready.
// A zero period, the first nonzero period of a set, and any period after
// saturation take the short path: the item goes straight to the done state,
// which registers the result once the output register is free. Folding a
// period into an existing value uses a one-bit-per-cycle divider twice
// (remainder, then quotient), a binary gcd on the narrow remainder, and a
// shift-add multiplier that consumes one period bit per cycle.
// One item is worked on at a time; a new item is taken once the previous one
// has moved into the output register, even if the receiver has not yet
// taken that result. A stalled receiver holds the result steady and the
// next item then waits for the output register to free up.
// Reset clears the running value and flags; an item marked last clears them
// again after its result is registered, ready for the next task set.
module hyperperiod_lcm_accumulator_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  hlcm_pkg::hlcm_in_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output hlcm_pkg::hlcm_out_t result
);
	import hlcm_pkg::*;

	localparam int ACC_W   = RESULT_BITS + PERIOD_BITS;
	localparam int K_W     = $clog2(PERIOD_BITS + 1);
	localparam int MCNT_W  = $clog2(PERIOD_BITS + 1);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV1 = 3'd1;
	localparam logic [2:0] S_GCD  = 3'd2;
	localparam logic [2:0] S_DIV2 = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_WB   = 3'd5;
	localparam logic [2:0] S_DONE = 3'd6;

	logic [2:0]             state_q;
	logic [RESULT_BITS-1:0] running_q;
	logic                   have_q;
	logic                   sticky_q;
	logic [PERIOD_BITS-1:0] p_q;
	logic                   last_q;
	logic [PERIOD_BITS-1:0] a_q;
	logic [PERIOD_BITS-1:0] b_q;
	logic [K_W-1:0]         k_q;
	logic [ACC_W-1:0]       acc_q;
	logic [PERIOD_BITS-1:0] mul_p_q;
	logic [MCNT_W-1:0]      mcnt_q;
	hlcm_out_t              result_q;
	logic                   result_valid_q;

	logic [PERIOD_BITS-1:0] p_in;
	logic                   p_wide;
	logic                   accept;
	logic                   out_free;
	logic                   gcd_fin;
	logic [PERIOD_BITS-1:0] g_w;
	logic                   div_start;
	logic [PERIOD_BITS-1:0] div_divisor;
	logic                   div_done;
	logic [RESULT_BITS-1:0] div_quo;
	logic [PERIOD_BITS-1:0] div_rem;
	logic [ACC_W-1:0]       acc_next;

	// Only the low PERIOD_BITS bits of the period field are used.
	assign p_in   = PERIOD_BITS'(item.period);
	assign p_wide = (PERIOD_BITS > RESULT_BITS) && ((p_in >> RESULT_BITS) != '0);

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign out_free   = !result_valid_q || result_ready;

	// Binary gcd ends when either operand reaches zero; the other one, scaled
	// back by the common power of two, is the gcd.
	assign gcd_fin = (a_q == '0) || (b_q == '0);
	assign g_w     = (a_q == '0) ? (b_q << k_q) : (a_q << k_q);

	// The divider first reduces the running value modulo the period, then
	// divides the running value by the gcd.
	assign div_start = (accept && (p_in != '0) && have_q && !sticky_q)
		|| ((state_q == S_GCD) && gcd_fin);
	assign div_divisor = (state_q == S_IDLE) ? p_in : g_w;

	hlcm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (running_q),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Shift-add multiply of the quotient by the period, period MSB first.
	assign acc_next = {acc_q[ACC_W-2:0], 1'b0}
		+ (mul_p_q[PERIOD_BITS-1] ? ACC_W'(div_quo) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			running_q      <= '0;
			have_q         <= 1'b0;
			sticky_q       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			// In S_DONE the output register is either refilled below or still
			// stalled, so the taken result is only dropped in other states.
			if (result_valid_q && result_ready && (state_q != S_DONE)) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (item_valid) begin
						if ((p_in == '0) || sticky_q) begin
							state_q <= S_DONE;
						end else if (!have_q) begin
							have_q <= 1'b1;
							if (p_wide) begin
								running_q <= RESULT_MAX;
								sticky_q  <= 1'b1;
							end else begin
								running_q <= RESULT_BITS'(p_in);
							end
							state_q <= S_DONE;
						end else begin
							state_q <= S_DIV1;
						end
					end
				end
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_GCD;
					end
				end
				S_GCD: begin
					if (gcd_fin) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mcnt_q == MCNT_W'(1)) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					if (acc_q[ACC_W-1:RESULT_BITS] != '0) begin
						running_q <= RESULT_MAX;
						sticky_q  <= 1'b1;
					end else begin
						running_q <= acc_q[RESULT_BITS-1:0];
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						result_valid_q <= 1'b1;
						if (last_q) begin
							running_q <= '0;
							have_q    <= 1'b0;
							sticky_q  <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers carry no reset; the control above qualifies them.
	always_ff @(posedge clk) begin
		if (accept) begin
			p_q    <= p_in;
			last_q <= item.last;
		end
		if ((state_q == S_DIV1) && div_done) begin
			a_q <= p_q;
			b_q <= div_rem;
			k_q <= '0;
		end else if ((state_q == S_GCD) && !gcd_fin) begin
			priority if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + K_W'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_q >= b_q) begin
				a_q <= (a_q - b_q) >> 1;
			end else begin
				b_q <= (b_q - a_q) >> 1;
			end
		end
		if ((state_q == S_DIV2) && div_done) begin
			acc_q   <= '0;
			mul_p_q <= p_q;
			mcnt_q  <= MCNT_W'(PERIOD_BITS);
		end else if (state_q == S_MUL) begin
			acc_q   <= acc_next;
			mul_p_q <= {mul_p_q[PERIOD_BITS-2:0], 1'b0};
			mcnt_q  <= mcnt_q - MCNT_W'(1);
		end
		if ((state_q == S_DONE) && out_free) begin
			result_q.hyperperiod <= HYPER_W'(running_q);
			result_q.overflow    <= sticky_q;
			result_q.final_res   <= last_q;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

`ifndef SYNTHESIS
	// Saturation always pins the running value at the all-ones code.
	a_sticky_max: assert property (@(posedge clk) disable iff (!arst_n)
		sticky_q |-> (running_q == RESULT_MAX))
		else $error("sticky overflow without saturated value");

	// Before the first nonzero period of a set there is no value and no flag.
	a_empty_set: assert property (@(posedge clk) disable iff (!arst_n)
		!have_q |-> ((running_q == '0) && !sticky_q))
		else $error("state left over in an empty set");

	// The shared divider only finishes while a fold is waiting for it.
	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> ((state_q == S_DIV1) || (state_q == S_DIV2)))
		else $error("divider finished outside a fold");

	// The gcd operands never both vanish, since the period is nonzero.
	a_gcd_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_GCD) |-> ((a_q != '0) || (b_q != '0)))
		else $error("gcd operands both zero");

	// An accepted item always leaves the idle state on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("item accepted but no work started");
`endif

endmodule
